[rtl/core/rau_pkg.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Action and status codes shared by the rational arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

  typedef logic [2:0] action_t;
  typedef logic [1:0] status_t;

  localparam action_t ACT_ADD = 3'd0;
  localparam action_t ACT_SUB = 3'd1;
  localparam action_t ACT_MUL = 3'd2;
  localparam action_t ACT_DIV = 3'd3;
  localparam action_t ACT_CMP = 3'd4;

  localparam status_t STAT_OK       = 2'd0;
  localparam status_t STAT_DIV_ZERO = 2'd1;
  localparam status_t STAT_OVERFLOW = 2'd2;

endpackage

`default_nettype wire

[rtl/core/rational_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Add, subtract, multiply, divide or compare two fractions; reduce the result
// by its greatest common divisor with one multiplier and one shared adder.
// ----------------------------------------------------------------------------
// Sequence: an unused action or a zero divisor ends in S_MUL_A, compare ends in
//   S_MUL_B, a zero numerator in S_GCD_INIT; otherwise the products, a binary
//   GCD and two restoring divisions (numerator, then denominator) lead to S_FINISH.
// Throughput: one transfer at a time; busy stays high until out_valid; the
//   receiver cannot stall. Reset: synchronous rst_n returns the sequencer to idle.
`default_nettype none

module rational_arithmetic_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  output logic                  busy,
  input  rau_pkg::action_t      in_action,
  input  wire  signed [31:0]    in_a_num,
  input  wire         [30:0]    in_a_den,
  input  wire  signed [31:0]    in_b_num,
  input  wire         [30:0]    in_b_den,
  output logic                  out_valid,
  output logic signed [31:0]    out_result_num,
  output logic        [30:0]    out_result_den,
  output logic                  out_is_equal,
  output rau_pkg::status_t      out_status
);

  import rau_pkg::*;

  localparam int MW = DATA_WIDTH;
  localparam int PW = 2 * DATA_WIDTH;
  localparam int KW = $clog2(PW);
  localparam logic [PW-1:0] NUM_LIMIT = {{(PW-MW){1'b0}}, 1'b1, {(MW-1){1'b0}}};
  localparam logic [PW-1:0] NUM_MAX   = NUM_LIMIT - 1'b1;
  localparam logic [KW-1:0] DIV_LAST  = KW'(PW - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_A, S_MUL_B, S_MUL_C, S_COMBINE, S_NEGATE,
    S_GCD_INIT, S_GCD, S_DIV_NUM, S_DIV_DEN, S_FINISH
  } state_t;

  state_t          state_r, state_nxt;
  action_t         action_r, action_nxt;
  logic            an_neg_r, an_neg_nxt;
  logic            bn_neg_r, bn_neg_nxt;
  logic [MW-1:0]   an_mag_r, an_mag_nxt;
  logic [MW-1:0]   bn_mag_r, bn_mag_nxt;
  logic [MW-2:0]   ad_r, ad_nxt;
  logic [MW-2:0]   bd_r, bd_nxt;
  logic [PW-1:0]   num_r, num_nxt;
  logic            num_neg_r, num_neg_nxt;
  logic [PW-1:0]   aux_r, aux_nxt;
  logic [PW-1:0]   den_r, den_nxt;
  logic [PW-1:0]   u_r, u_nxt;
  logic [PW-1:0]   v_r, v_nxt;
  logic [KW-1:0]   k_r, k_nxt;
  logic [PW-1:0]   g_r, g_nxt;
  logic [PW-1:0]   rem_r, rem_nxt;
  logic [PW-1:0]   quo_r, quo_nxt;
  logic [KW-1:0]   cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [31:0]     out_num_r, out_num_nxt;
  logic [30:0]     out_den_r, out_den_nxt;
  logic            out_eq_r, out_eq_nxt;
  status_t         out_status_r, out_status_nxt;

  logic [MW-1:0]   mul_x, mul_y;
  logic [PW-1:0]   mul_p;
  logic [PW:0]     alu_a, alu_b;
  logic            alu_sub;
  logic [PW+1:0]   alu_bx, alu_res;
  logic            alu_borrow;

  logic [MW-1:0]   an_raw, bn_raw;
  logic [MW-1:0]   ad_ext, bd_ext;
  logic            r_neg;
  logic [PW-1:0]   quo_step, rem_step;
  logic            ovf;
  logic [31:0]     mag32;

  assign mul_p      = {{MW{1'b0}}, mul_x} * {{MW{1'b0}}, mul_y};
  assign alu_bx     = alu_sub ? ~{1'b0, alu_b} : {1'b0, alu_b};
  assign alu_res    = {1'b0, alu_a} + alu_bx + {{(PW+1){1'b0}}, alu_sub};
  assign alu_borrow = alu_res[PW+1];

  assign an_raw = in_a_num[MW-1:0];
  assign bn_raw = in_b_num[MW-1:0];
  assign ad_ext = {1'b0, ad_r};
  assign bd_ext = {1'b0, bd_r};
  assign r_neg  = bn_neg_r ^ (action_r == ACT_SUB);

  assign quo_step = {quo_r[PW-2:0], ~alu_borrow};
  assign rem_step = alu_borrow ? alu_a[PW-1:0] : alu_res[PW-1:0];

  assign ovf   = (den_r > NUM_MAX) || (num_neg_r ? (num_r > NUM_LIMIT) : (num_r > NUM_MAX));
  assign mag32 = 32'(num_r[MW-1:0]);

  always_comb begin
    state_nxt      = state_r;
    action_nxt     = action_r;
    an_neg_nxt     = an_neg_r;
    bn_neg_nxt     = bn_neg_r;
    an_mag_nxt     = an_mag_r;
    bn_mag_nxt     = bn_mag_r;
    ad_nxt         = ad_r;
    bd_nxt         = bd_r;
    num_nxt        = num_r;
    num_neg_nxt    = num_neg_r;
    aux_nxt        = aux_r;
    den_nxt        = den_r;
    u_nxt          = u_r;
    v_nxt          = v_r;
    k_nxt          = k_r;
    g_nxt          = g_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = 1'b0;
    out_num_nxt    = out_num_r;
    out_den_nxt    = out_den_r;
    out_eq_nxt     = out_eq_r;
    out_status_nxt = out_status_r;
    mul_x          = an_mag_r;
    mul_y          = bd_ext;
    alu_a          = {1'b0, num_r};
    alu_b          = {1'b0, aux_r};
    alu_sub        = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          action_nxt = in_action;
          an_neg_nxt = an_raw[MW-1];
          bn_neg_nxt = bn_raw[MW-1];
          an_mag_nxt = an_raw[MW-1] ? (~an_raw + 1'b1) : an_raw;
          bn_mag_nxt = bn_raw[MW-1] ? (~bn_raw + 1'b1) : bn_raw;
          ad_nxt     = in_a_den[MW-2:0];
          bd_nxt     = in_b_den[MW-2:0];
          state_nxt  = S_MUL_A;
        end
      end
      S_MUL_A: begin
        mul_x = an_mag_r;
        mul_y = (action_r == ACT_MUL) ? bn_mag_r : bd_ext;
        out_num_nxt = 32'd0;
        out_den_nxt = 31'd1;
        out_eq_nxt  = 1'b0;
        if (action_r > ACT_CMP) begin
          out_status_nxt = STAT_OK;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else if (ad_r == '0 || bd_r == '0 ||
                     (action_r == ACT_DIV && bn_mag_r == '0)) begin
          out_status_nxt = STAT_DIV_ZERO;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          num_nxt     = mul_p;
          num_neg_nxt = an_neg_r ^ ((action_r == ACT_MUL || action_r == ACT_DIV) & bn_neg_r);
          state_nxt   = S_MUL_B;
        end
      end
      S_MUL_B: begin
        if (action_r == ACT_MUL) begin
          mul_x = ad_ext;
          mul_y = bd_ext;
        end else if (action_r == ACT_DIV) begin
          mul_x = ad_ext;
          mul_y = bn_mag_r;
        end else begin
          mul_x = bn_mag_r;
          mul_y = ad_ext;
        end
        if (action_r == ACT_CMP) begin
          out_num_nxt    = 32'd0;
          out_den_nxt    = 31'd1;
          out_eq_nxt     = (num_r == mul_p) && (num_r == '0 || an_neg_r == bn_neg_r);
          out_status_nxt = STAT_OK;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else if (action_r == ACT_MUL || action_r == ACT_DIV) begin
          den_nxt   = mul_p;
          state_nxt = S_GCD_INIT;
        end else begin
          aux_nxt   = mul_p;
          state_nxt = S_MUL_C;
        end
      end
      S_MUL_C: begin
        mul_x     = ad_ext;
        mul_y     = bd_ext;
        den_nxt   = mul_p;
        state_nxt = S_COMBINE;
      end
      S_COMBINE: begin
        alu_a   = {1'b0, num_r};
        alu_b   = {1'b0, aux_r};
        alu_sub = (num_neg_r != r_neg);
        num_nxt = alu_res[PW-1:0];
        if (alu_sub && alu_borrow) begin
          num_neg_nxt = r_neg;
          state_nxt   = S_NEGATE;
        end else begin
          state_nxt = S_GCD_INIT;
        end
      end
      S_NEGATE: begin
        alu_a     = '0;
        alu_b     = {1'b0, num_r};
        alu_sub   = 1'b1;
        num_nxt   = alu_res[PW-1:0];
        state_nxt = S_GCD_INIT;
      end
      S_GCD_INIT: begin
        if (num_r == '0) begin
          out_num_nxt    = 32'd0;
          out_den_nxt    = 31'd1;
          out_eq_nxt     = 1'b0;
          out_status_nxt = STAT_OK;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          u_nxt     = num_r;
          v_nxt     = den_r;
          k_nxt     = '0;
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        alu_a   = {1'b0, u_r};
        alu_b   = {1'b0, v_r};
        alu_sub = 1'b1;
        if (u_r == v_r) begin
          g_nxt     = u_r << k_r;
          rem_nxt   = '0;
          quo_nxt   = num_r;
          cnt_nxt   = DIV_LAST;
          state_nxt = S_DIV_NUM;
        end else if (!u_r[0] && !v_r[0]) begin
          u_nxt = u_r >> 1;
          v_nxt = v_r >> 1;
          k_nxt = k_r + 1'b1;
        end else if (!u_r[0]) begin
          u_nxt = u_r >> 1;
        end else if (!v_r[0]) begin
          v_nxt = v_r >> 1;
        end else if (alu_borrow) begin
          u_nxt = v_r;
          v_nxt = u_r;
        end else begin
          u_nxt = alu_res[PW-1:0];
        end
      end
      S_DIV_NUM, S_DIV_DEN: begin
        alu_a   = {rem_r, quo_r[PW-1]};
        alu_b   = {1'b0, g_r};
        alu_sub = 1'b1;
        rem_nxt = rem_step;
        quo_nxt = quo_step;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          if (state_r == S_DIV_NUM) begin
            num_nxt   = quo_step;
            rem_nxt   = '0;
            quo_nxt   = den_r;
            cnt_nxt   = DIV_LAST;
            state_nxt = S_DIV_DEN;
          end else begin
            den_nxt   = quo_step;
            state_nxt = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        out_eq_nxt    = 1'b0;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (ovf) begin
          out_num_nxt    = 32'd0;
          out_den_nxt    = 31'd1;
          out_status_nxt = STAT_OVERFLOW;
        end else begin
          out_num_nxt    = num_neg_r ? (32'd0 - mag32) : mag32;
          out_den_nxt    = 31'(den_r[MW-2:0]);
          out_status_nxt = STAT_OK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    action_r     <= action_nxt;
    an_neg_r     <= an_neg_nxt;
    bn_neg_r     <= bn_neg_nxt;
    an_mag_r     <= an_mag_nxt;
    bn_mag_r     <= bn_mag_nxt;
    ad_r         <= ad_nxt;
    bd_r         <= bd_nxt;
    num_r        <= num_nxt;
    num_neg_r    <= num_neg_nxt;
    aux_r        <= aux_nxt;
    den_r        <= den_nxt;
    u_r          <= u_nxt;
    v_r          <= v_nxt;
    k_r          <= k_nxt;
    g_r          <= g_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    cnt_r        <= cnt_nxt;
    out_num_r    <= out_num_nxt;
    out_den_r    <= out_den_nxt;
    out_eq_r     <= out_eq_nxt;
    out_status_r <= out_status_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_result_num = out_num_r;
  assign out_result_den = out_den_r;
  assign out_is_equal   = out_eq_r;
  assign out_status     = out_status_r;

endmodule

`default_nettype wire

[test/rau_checker.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit result checker
// Watches the command and result ports. Each accepted command is reduced by
// the checker's own fraction arithmetic. The predicted result is queued and
// compared field by field with the next result strobe. The failure count and
// the number of results still owed go back to the testbench top.
// ----------------------------------------------------------------------------
module rau_checker #(
  parameter int DATA_WIDTH = 32
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  input  wire                 busy,
  input  rau_pkg::action_t    in_action,
  input  wire  signed [31:0]  in_a_num,
  input  wire         [30:0]  in_a_den,
  input  wire  signed [31:0]  in_b_num,
  input  wire         [30:0]  in_b_den,
  input  wire                 out_valid,
  input  wire  signed [31:0]  out_result_num,
  input  wire         [30:0]  out_result_den,
  input  wire                 out_is_equal,
  input  rau_pkg::status_t    out_status,
  output int                  error_total,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import rau_pkg::*;

  localparam int WW = 2 * DATA_WIDTH + 2;
  localparam logic [63:0] MAG_LIMIT = 64'd1 << (DATA_WIDTH - 1);

  typedef logic signed [WW-1:0] wide_t;

  typedef struct packed {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic               is_equal;
    status_t            status;
  } fraction_t;

  fraction_t reduced_q[$];
  int mismatches = 0;

  function automatic fraction_t reduce_fraction(action_t act, logic [31:0] a_num,
                                                logic [30:0] a_den, logic [31:0] b_num,
                                                logic [30:0] b_den);
    wide_t an, ad, bn, bd, num, den_w;
    logic [63:0] mag, den, g, r, t;
    logic neg;
    fraction_t res;
    res.num = '0;
    res.den = 31'd1;
    res.is_equal = 1'b0;
    res.status = STAT_OK;
    an = wide_t'($signed(a_num[DATA_WIDTH-1:0]));
    bn = wide_t'($signed(b_num[DATA_WIDTH-1:0]));
    ad = wide_t'({1'b0, a_den[DATA_WIDTH-2:0]});
    bd = wide_t'({1'b0, b_den[DATA_WIDTH-2:0]});
    if (act > ACT_CMP) return res;
    if (ad == 0 || bd == 0) begin
      res.status = STAT_DIV_ZERO;
      return res;
    end
    case (act)
      ACT_CMP: begin
        res.is_equal = (an * bd == bn * ad);
        return res;
      end
      ACT_ADD: begin
        num = an * bd + bn * ad;
        den_w = ad * bd;
      end
      ACT_SUB: begin
        num = an * bd - bn * ad;
        den_w = ad * bd;
      end
      ACT_MUL: begin
        num = an * bn;
        den_w = ad * bd;
      end
      default: begin
        if (bn == 0) begin
          res.status = STAT_DIV_ZERO;
          return res;
        end
        num = (bn < 0) ? -(an * bd) : an * bd;
        den_w = (bn < 0) ? -(bn * ad) : bn * ad;
      end
    endcase
    if (num == 0) return res;
    neg = (num < 0);
    mag = neg ? 64'(-num) : 64'(num);
    den = 64'(den_w);
    g = mag;
    r = den;
    while (r != 0) begin
      t = g % r;
      g = r;
      r = t;
    end
    mag = mag / g;
    den = den / g;
    if (den > MAG_LIMIT - 1 || (neg ? mag > MAG_LIMIT : mag > MAG_LIMIT - 1)) begin
      res.status = STAT_OVERFLOW;
      return res;
    end
    res.num = neg ? 32'(-mag) : 32'(mag);
    res.den = 31'(den);
    return res;
  endfunction

  always @(posedge clk) begin
    fraction_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (reduced_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%t: unexpected result %0d/%0d eq=%0b st=%0d", $time,
                     out_result_num, out_result_den, out_is_equal, out_status);
        end else begin
          want = reduced_q.pop_front();
          if (out_result_num !== want.num || out_result_den !== want.den ||
              out_is_equal !== want.is_equal || out_status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%t: expected %0d/%0d eq=%0b st=%0d, got %0d/%0d eq=%0b st=%0d",
                       $time, $signed(want.num), want.den, want.is_equal, want.status,
                       out_result_num, out_result_den, out_is_equal, out_status);
          end
        end
      end
      if (start && !busy)
        reduced_q.push_back(reduce_fraction(in_action, in_a_num, in_a_den,
                                            in_b_num, in_b_den));
    end
    error_total <= mismatches;
    pending <= reduced_q.size();
  end

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives directed fraction cases (extremes, every action, zero operands,
// zero denominators, overflow bounds, unused actions) and then random
// commands with random sender gaps. The checker predicts and compares every
// result; this module makes stimulus, runs the watchdog and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rau_pkg::*;

  localparam int DATA_WIDTH       = 32;
  localparam int RANDOM_TRANSFERS = 1600;
  localparam int CALM_TAIL        = 300;
  localparam int DRAIN_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT   = 4000;

  localparam action_t ACT_SPARE_FIRST = 3'd5;
  localparam action_t ACT_SPARE_LAST  = 3'd7;

  localparam logic signed [31:0] NUM_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] NUM_MAX = 32'sh7FFF_FFFF;
  localparam logic [30:0]        DEN_MAX = 31'h7FFF_FFFF;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  action_t            in_action = ACT_ADD;
  logic signed [31:0] in_a_num = '0;
  logic        [30:0] in_a_den = 31'd1;
  logic signed [31:0] in_b_num = '0;
  logic        [30:0] in_b_den = 31'd1;

  logic               busy;
  logic               out_valid;
  logic signed [31:0] out_result_num;
  logic        [30:0] out_result_den;
  logic               out_is_equal;
  status_t            out_status;

  int error_total;
  int pending;
  int quiet_cycles = 0;

  always #4 clk = ~clk;

  rational_arithmetic_unit #(
    .DATA_WIDTH(DATA_WIDTH)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_a_num       (in_a_num),
    .in_a_den       (in_a_den),
    .in_b_num       (in_b_num),
    .in_b_den       (in_b_den),
    .out_valid      (out_valid),
    .out_result_num (out_result_num),
    .out_result_den (out_result_den),
    .out_is_equal   (out_is_equal),
    .out_status     (out_status)
  );

  rau_checker #(
    .DATA_WIDTH(DATA_WIDTH)
  ) result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_a_num       (in_a_num),
    .in_a_den       (in_a_den),
    .in_b_num       (in_b_num),
    .in_b_den       (in_b_den),
    .out_valid      (out_valid),
    .out_result_num (out_result_num),
    .out_result_den (out_result_den),
    .out_is_equal   (out_is_equal),
    .out_status     (out_status),
    .error_total    (error_total),
    .pending        (pending)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL rational_arithmetic_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // hold the command until the transfer edge
  task automatic issue(action_t act, logic signed [31:0] a_num, logic [30:0] a_den,
                       logic signed [31:0] b_num, logic [30:0] b_den);
    start <= 1'b1;
    in_action <= act;
    in_a_num <= a_num;
    in_a_den <= a_den;
    in_b_num <= b_num;
    in_b_den <= b_den;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_num();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0: return NUM_MIN;
          1: return NUM_MAX;
          2: return -32'sd1;
          3: return '0;
          default: return 32'sd1;
        endcase
      end
      2, 3: return 32'($urandom_range(0, 131071)) - 32'd65536;
      default: return 32'($urandom_range(0, 40)) - 32'd20;
    endcase
  endfunction

  function automatic logic [30:0] pick_den();
    case ($urandom_range(0, 7))
      0: return 31'($urandom);
      1: begin
        case ($urandom_range(0, 2))
          0: return 31'd1;
          1: return DEN_MAX;
          default: return DEN_MAX - 31'd1;
        endcase
      end
      2, 3: return 31'($urandom_range(1, 65535));
      default: return 31'($urandom_range(1, 30));
    endcase
  endfunction

  task automatic random_transfer();
    action_t            act;
    logic signed [31:0] an, bn;
    logic        [30:0] ad, bd;
    int                 scale;
    int unsigned        pick;
    pick = $urandom_range(0, 99);
    act = action_t'($urandom_range(ACT_ADD, ACT_CMP));
    an = pick_num();
    bn = pick_num();
    ad = pick_den();
    bd = pick_den();
    if (pick < 5) begin
      act = action_t'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
    end else if (pick < 9) begin
      if ($urandom_range(0, 1)) ad = '0;
      else bd = '0;
    end else if (pick < 25) begin
      // scaled copy of the left fraction, sometimes off by one
      an = 32'($urandom_range(0, 60)) - 32'd30;
      ad = 31'($urandom_range(1, 40));
      scale = $urandom_range(1, 50);
      bn = an * scale;
      bd = 31'(ad * scale);
      if (pick < 14) act = ACT_CMP;
      if (pick[0]) bn = bn + 32'sd1;
    end else if (pick < 30) begin
      bn = an;
      bd = ad;
    end
    issue(act, an, ad, bn, bd);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(ACT_ADD, 1, 2, 1, 3);
    issue(ACT_SUB, 1, 2, 1, 2);
    issue(ACT_SUB, -5, 6, 1, 3);
    issue(ACT_MUL, -3, 4, 2, 3);
    issue(ACT_DIV, 1, 2, -1, 4);
    issue(ACT_DIV, -7, 3, -14, 9);
    issue(ACT_DIV, 5, 7, 0, 3);
    issue(ACT_CMP, 0, 3, 0, 5);
    issue(ACT_CMP, 1, 2, 2, 4);
    issue(ACT_CMP, 1, 2, -1, 2);
    issue(ACT_ADD, 3, 0, 1, 1);
    issue(ACT_CMP, 1, 1, 1, 0);
    issue(ACT_MUL, 0, DEN_MAX, NUM_MIN, 1);
    for (int c = ACT_SPARE_FIRST; c <= ACT_SPARE_LAST; c++)
      issue(action_t'(c), NUM_MAX, 3, -9, DEN_MAX);
    issue(ACT_ADD, NUM_MAX, 1, 1, 1);
    issue(ACT_SUB, NUM_MIN, 1, NUM_MAX, 1);
    issue(ACT_MUL, NUM_MIN, 1, NUM_MIN, 1);
    issue(ACT_MUL, NUM_MIN, 1, -1, 1);
    issue(ACT_DIV, NUM_MIN, 1, 1, 1);
    issue(ACT_MUL, 1, DEN_MAX, 1, 2);
    issue(ACT_DIV, NUM_MAX, DEN_MAX, NUM_MAX, DEN_MAX);
    issue(ACT_ADD, NUM_MIN, DEN_MAX, NUM_MIN, DEN_MAX);
    issue(ACT_CMP, NUM_MAX, DEN_MAX, NUM_MAX, DEN_MAX);

    for (int i = 0; i < RANDOM_TRANSFERS; i++) begin
      random_transfer();
      if (i < RANDOM_TRANSFERS - CALM_TAIL && (i / 64) % 3 != 2 &&
          $urandom_range(0, 3) == 0)
        pause($urandom_range(1, 9));
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_total == 0 && pending == 0)
      $display("PASS rational_arithmetic_unit");
    else
      $display("FAIL rational_arithmetic_unit");
    $finish;
  end

endmodule
